@@ src/ubx_fbc_pkg.sv @@
// ----------------------------------------------------------------------------
// UBX frame build and check package
// Shared types and constants for the UBX framer and checksum checker.
// ----------------------------------------------------------------------------
package ubx_fbc_pkg;

    // Sync characters that open every UBX frame.
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // Most results a single request can cause.
    localparam int unsigned MAX_RESULTS = 3;

    // Depth of the result queue and the widths that follow from it.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // A request is taken only while this many queue entries or fewer are used.
    localparam int unsigned ACCEPT_LIMIT = QUEUE_DEPTH - MAX_RESULTS;

    // Check mode counts frame bytes up to this saturating value.
    localparam logic [2:0] SEEN_MAX = 3'd7;

    // Frame index from which the delayed byte enters the sums.
    localparam logic [2:0] SUM_START_IDX = 3'd4;

    // Frame index from which a verdict can pass.
    localparam logic [2:0] PASS_MIN_IDX = 3'd3;

    typedef enum logic
    {
        MODE_BUILD = 1'b0,
        MODE_CHECK = 1'b1
    } mode_t;

    typedef struct packed
    {
        mode_t      mode;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       is_verdict;
        logic       check_pass;
        logic       run_last;
        logic       frame_end;
    } result_t;

endpackage

@@ src/ubx_frame_build_and_check_core.sv @@
// ----------------------------------------------------------------------------
// UBX frame build and check core
// Builds outgoing UBX frames (sync pair, content, Fletcher checksum) and
// checks the Fletcher checksum of received frames, one byte per request.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                          | Direction | Moves
//  ---------+----------------------------------+-----------+-----------------
//  item     | item_valid, item_stall, item     | into core | one frame byte
//  result   | result_valid, result_stall,      | out of    | one framed byte
//           | result                           | core      | or one verdict
//
// A request is handled in the cycle it is accepted: the sums, the two-byte
// delay line and the byte count are updated, and the zero to three results
// it causes are written into a four-entry result queue in the same edge.
// The queue drains one result per cycle unless result_stall is high, so
// requests that cause at most one result are taken at one per cycle; a
// request that causes three (build-mode first or last byte) holds off later
// requests while the queue drains. item_stall is high while the queue holds
// more than one result, which leaves room for the largest burst; it comes
// from a register only. Reset is asynchronous and clears the sums, the delay
// line, the byte count and the queue; a request can be accepted as soon as
// reset is released. A stalled result stays at the queue head unchanged.
//
module ubx_frame_build_and_check_core
    import ubx_fbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // Running state of the frame.
    logic [7:0] sum_a_reg;
    logic [7:0] sum_a_next;
    logic [7:0] sum_b_reg;
    logic [7:0] sum_b_next;
    logic [7:0] delay0_reg;
    logic [7:0] delay0_next;
    logic [7:0] delay1_reg;
    logic [7:0] delay1_next;
    logic [2:0] seen_reg;
    logic [2:0] seen_next;

    // Result queue.
    result_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [PTR_W-1:0]     wr_ptr;

    logic                 accept;
    logic                 pop;
    result_t              res [MAX_RESULTS];
    logic [1:0]           res_count;

    // Frame state as seen by this request: a first byte starts from zero.
    logic [7:0] base_a;
    logic [7:0] base_b;
    logic [7:0] base_d0;
    logic [7:0] base_d1;
    logic [2:0] base_seen;
    logic [7:0] add_byte;
    logic       do_add;
    logic [7:0] new_a;
    logic [7:0] new_b;
    logic [7:0] sums_a;
    logic [7:0] sums_b;
    logic       pass;

    assign item_stall   = (cnt_reg > CNT_W'(ACCEPT_LIMIT));
    assign accept       = item_valid && !item_stall;
    assign result_valid = (cnt_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign result       = queue_reg[rd_ptr_reg];
    assign wr_ptr       = rd_ptr_reg + cnt_reg[PTR_W-1:0];

    always_comb
    begin
        base_a    = item.first_byte ? 8'd0 : sum_a_reg;
        base_b    = item.first_byte ? 8'd0 : sum_b_reg;
        base_d0   = item.first_byte ? 8'd0 : delay0_reg;
        base_d1   = item.first_byte ? 8'd0 : delay1_reg;
        base_seen = item.first_byte ? 3'd0 : seen_reg;

        // Build mode folds in the new byte; check mode folds in the byte two
        // places back, once the frame is past its sync pair and the two
        // checksum bytes cannot be among the summed ones.
        if (item.mode == MODE_BUILD)
        begin
            add_byte = item.data_byte;
            do_add   = 1'b1;
        end
        else
        begin
            add_byte = base_d1;
            do_add   = (base_seen >= SUM_START_IDX);
        end

        new_a  = base_a + add_byte;
        new_b  = base_b + new_a;
        sums_a = do_add ? new_a : base_a;
        sums_b = do_add ? new_b : base_b;

        pass = (base_seen >= PASS_MIN_IDX) && (base_d0 == sums_a)
            && (item.data_byte == sums_b);
    end

    // State update and the results of this request.
    always_comb
    begin
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        delay0_next = delay0_reg;
        delay1_next = delay1_reg;
        seen_next   = seen_reg;
        res_count   = 2'd0;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            res[k] = '0;
        end

        if (accept)
        begin
            sum_a_next = sums_a;
            sum_b_next = sums_b;
            if (item.mode == MODE_BUILD)
            begin
                delay0_next = base_d0;
                delay1_next = base_d1;
                seen_next   = base_seen;
                if (item.first_byte)
                begin
                    // Sync pair ahead of the class byte. A last mark on the
                    // same byte is dropped, since the frame cannot close here.
                    res[0].out_byte = SYNC_FIRST;
                    res[1].out_byte = SYNC_SECOND;
                    res[2].out_byte = item.data_byte;
                    res[2].run_last = 1'b1;
                    res_count       = 2'd3;
                end
                else if (item.last_byte)
                begin
                    res[0].out_byte  = item.data_byte;
                    res[1].out_byte  = new_a;
                    res[2].out_byte  = new_b;
                    res[2].run_last  = 1'b1;
                    res[2].frame_end = 1'b1;
                    res_count        = 2'd3;
                end
                else
                begin
                    res[0].out_byte = item.data_byte;
                    res[0].run_last = 1'b1;
                    res_count       = 2'd1;
                end
            end
            else
            begin
                delay0_next = item.data_byte;
                delay1_next = base_d0;
                seen_next   = (base_seen < SEEN_MAX) ? base_seen + 3'd1 : base_seen;
                if (item.last_byte)
                begin
                    res[0].is_verdict = 1'b1;
                    res[0].check_pass = pass;
                    res[0].run_last   = 1'b1;
                    res[0].frame_end  = 1'b1;
                    res_count         = 2'd1;
                end
            end
        end

        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg - CNT_W'(pop) + CNT_W'(res_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            delay0_reg <= '0;
            delay1_reg <= '0;
            seen_reg   <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            delay0_reg <= delay0_next;
            delay1_reg <= delay1_next;
            seen_reg   <= seen_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage needs no reset: entries are only read once written.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (2'(k) < res_count)
            begin
                queue_reg[wr_ptr + PTR_W'(k)] <= res[k];
            end
        end
    end

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // A build-mode first byte leaves at least three results queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.mode == MODE_BUILD && item.first_byte) |=> (cnt_reg >= CNT_W'(3)))
        else $error("sync burst not queued");

    // A frame end is always the last result of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.frame_end) |-> result.run_last)
        else $error("frame end without run end");

    // A verdict carries no byte and closes the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_verdict) |-> (result.out_byte == 8'd0 && result.frame_end))
        else $error("malformed verdict");

    // The check-mode byte count stays saturated within a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.mode == MODE_CHECK && !item.first_byte && seen_reg == SEEN_MAX)
        |=> (seen_reg == SEEN_MAX))
        else $error("byte count wrapped");

endmodule
